FILE: design/nrs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the NACK receive scoreboard.
package nrs_pkg;

   localparam int unsigned MAX_PACKETS_DEFAULT   = 65536;
   localparam int unsigned PAYLOAD_BYTES_DEFAULT = 1250;

   // The seen bitmap is held as words of this many sequence bits.
   localparam int unsigned MAP_WORD_BITS = 32;
   localparam int unsigned BIT_IDX_W     = 5;

   localparam int unsigned PACKET_COUNT_W = 17;
   localparam int unsigned LAST_BYTES_W   = 11;
   localparam int unsigned CSR_DATA_W     = 17;
   localparam int unsigned CSR_INDEX_W    = 1;
   localparam int unsigned SEQ_NUM_W      = 32;
   localparam int unsigned KIND_W         = 3;
   localparam int unsigned OFFSET_W       = 27;
   localparam int unsigned LENGTH_W       = 11;
   localparam int unsigned NACK_W         = 16;

   // floor(n / 5) == (n * RECIP5) >> RECIP5_SHIFT for every n below 2**22.
   localparam int unsigned RECIP5       = 838861;
   localparam int unsigned RECIP5_W     = 20;
   localparam int unsigned RECIP5_SHIFT = 22;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PACKET_COUNT = 1'b0,
      CSR_LAST_BYTES   = 1'b1
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_DROPPED  = 3'd1,
      KIND_NACK     = 3'd2,
      KIND_NO_NACK  = 3'd3,
      KIND_IDLE     = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ARR_READ,
      ST_ARR_CHECK,
      ST_ARR_RECOVER,
      ST_TICK_START,
      ST_PFX_READ,
      ST_PFX_CHECK,
      ST_SCAN_START,
      ST_SCAN_READ,
      ST_SCAN_CHECK,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_ARR_CHECK,
      OP_RECOVER,
      OP_TICK_START,
      OP_PFX_CHECK,
      OP_SCAN_START,
      OP_SCAN_EXHAUST,
      OP_SCAN_CHECK,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      ADDR_CLEAR,
      ADDR_ITEM,
      ADDR_PREFIX,
      ADDR_CURSOR
   } addr_sel_type;

   typedef struct packed {
      op_type       op;
      addr_sel_type addr_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic tick_active;
      logic pfx_go;
      logic pfx_cont;
      logic scan_go;
      logic scan_cont;
      logic out_free;
   } dp_status_type;

   // Returns {found, index} of the lowest set bit of a bitmap word.
   function automatic logic [BIT_IDX_W:0] first_set(input logic [MAP_WORD_BITS-1:0] v);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return {(|v), idx};
   endfunction

endpackage

FILE: design/nrs_req_if.sv
`timescale 1ns / 1ps
// Request channel: packet arrivals and NACK timer ticks.
interface nrs_req_if import nrs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic signed [SEQ_NUM_W-1:0] seq_num;

   modport source (output valid, output command, output seq_num, input ready);
   modport sink (input valid, input command, input seq_num, output ready);
endinterface

FILE: design/nrs_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: one result word per request word.
interface nrs_rsp_if import nrs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   result_kind;
   logic [OFFSET_W-1:0] write_offset;
   logic [LENGTH_W-1:0] write_length;
   logic [NACK_W-1:0]   nack_seq;
   logic                complete;

   modport source (output valid, output result_kind, output write_offset,
                   output write_length, output nack_seq, output complete, input ready);
   modport sink (input valid, input result_kind, input write_offset,
                 input write_length, input nack_seq, input complete, output ready);
endinterface

FILE: design/nrs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module nrs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: design/nrs_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the NACK receive scoreboard.
module nrs_ctrl import nrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = req_command ? ST_TICK_START : ST_ARR_READ;
         end
         ST_ARR_READ:    state_in = ST_ARR_CHECK;
         ST_ARR_CHECK:   state_in = ST_ARR_RECOVER;
         ST_ARR_RECOVER: state_in = ST_FINISH;
         ST_TICK_START: begin
            state_in = status.tick_active ? ST_PFX_READ : ST_FINISH;
         end
         ST_PFX_READ: begin
            state_in = status.pfx_go ? ST_PFX_CHECK : ST_SCAN_START;
         end
         ST_PFX_CHECK: begin
            state_in = status.pfx_cont ? ST_PFX_READ : ST_SCAN_START;
         end
         ST_SCAN_START: state_in = ST_SCAN_READ;
         ST_SCAN_READ: begin
            state_in = status.scan_go ? ST_SCAN_CHECK : ST_FINISH;
         end
         ST_SCAN_CHECK: begin
            state_in = status.scan_cont ? ST_SCAN_READ : ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.addr_sel = ADDR_ITEM;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op       = OP_CLEAR;
            cmd.addr_sel = ADDR_CLEAR;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_ARR_READ:    cmd.addr_sel = ADDR_ITEM;
         ST_ARR_CHECK:   cmd.op = OP_ARR_CHECK;
         ST_ARR_RECOVER: cmd.op = OP_RECOVER;
         ST_TICK_START:  cmd.op = OP_TICK_START;
         ST_PFX_READ:    cmd.addr_sel = ADDR_PREFIX;
         ST_PFX_CHECK: begin
            cmd.op       = OP_PFX_CHECK;
            cmd.addr_sel = ADDR_PREFIX;
         end
         ST_SCAN_START:  cmd.op = OP_SCAN_START;
         ST_SCAN_READ: begin
            cmd.op       = status.scan_go ? OP_NONE : OP_SCAN_EXHAUST;
            cmd.addr_sel = ADDR_CURSOR;
         end
         ST_SCAN_CHECK: begin
            cmd.op       = OP_SCAN_CHECK;
            cmd.addr_sel = ADDR_CURSOR;
         end
         ST_FINISH:      cmd.op = OP_FINISH;
         default:        cmd.op = OP_NONE;
      endcase
   end

   // A word taken in idle always starts an arrival or a tick sequence.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_ARR_READ || state_ff == ST_TICK_START))
      else $error("accepted word did not start a sequence");

   // A finished result waits in FINISH until the output register frees up.
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !status.out_free) |=> state_ff == ST_FINISH)
      else $error("result left FINISH while output register was full");

   // Nothing is accepted until the bitmap clearing pass has finished.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> cmd.op == OP_CLEAR && !req_ready)
      else $error("word accepted during bitmap clear");
endmodule

FILE: design/nrs_datapath.sv
`timescale 1ns / 1ps
// Datapath: registers, scoreboard state, bitmap word search and result register.
module nrs_datapath import nrs_pkg::*; #(
   parameter int unsigned MAX_PACKETS   = MAX_PACKETS_DEFAULT,
   parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT,
   localparam int unsigned Words = (MAX_PACKETS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
   localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data,
   input  logic                        req_command,
   input  logic signed [SEQ_NUM_W-1:0] req_seq_num,
   input  ctrl_cmd_type                cmd,
   output dp_status_type               status,
   output logic                        mem_we,
   output logic [AddrW-1:0]            mem_waddr,
   output logic [MAP_WORD_BITS-1:0]    mem_wdata,
   output logic [AddrW-1:0]            mem_raddr,
   input  logic [MAP_WORD_BITS-1:0]    mem_rdata,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [KIND_W-1:0]           rsp_result_kind,
   output logic [OFFSET_W-1:0]         rsp_write_offset,
   output logic [LENGTH_W-1:0]         rsp_write_length,
   output logic [NACK_W-1:0]           rsp_nack_seq,
   output logic                        rsp_complete
);
   localparam int unsigned SeqW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam int unsigned CntW = SeqW + 1;
   localparam int unsigned ProdW = CntW + RECIP5_W;

   // Configuration and scoreboard state
   logic [PACKET_COUNT_W-1:0] pkt_count_ff;
   logic [LAST_BYTES_W-1:0]   last_bytes_ff;
   logic [CntW-1:0]           n_div5_ff;
   logic [CntW-1:0]           dp_ff, dp_in;
   logic [SeqW-1:0]           high_ff, high_in;
   logic [CntW-1:0]           count_ff, count_in;
   logic [CntW-1:0]           sp_ff, sp_in;
   logic                      rec_ff, rec_in;
   logic [CntW-1:0]           cur_ff, cur_in;
   logic [CntW-1:0]           lim_ff, lim_in;
   logic [AddrW-1:0]          clr_ff;
   logic                      out_valid_ff;

   // Item and result payload
   logic                      item_tick_ff;
   logic [SEQ_NUM_W-1:0]      item_seq_ff;
   kind_type                  res_kind_ff, res_kind_in;
   logic [OFFSET_W-1:0]       res_off_ff, res_off_in;
   logic [LENGTH_W-1:0]       res_len_ff, res_len_in;
   logic [NACK_W-1:0]         res_nack_ff, res_nack_in;
   logic [KIND_W-1:0]         out_kind_ff;
   logic [OFFSET_W-1:0]       out_off_ff;
   logic [LENGTH_W-1:0]       out_len_ff;
   logic [NACK_W-1:0]         out_nack_ff;
   logic                      out_complete_ff;

   logic [CntW-1:0]           n_eff;
   logic [ProdW-1:0]          n_prod;
   logic [31:0]               n32, h32, seq32, dp32, cur32, pos32, base32, cand32, lim32;
   logic [31:0]               hor32, limit_new32;
   logic [BIT_IDX_W:0]        search;
   logic                      found, in_range, hit, fresh, out_load, complete_now;
   logic [BIT_IDX_W-1:0]      seq_bit;
   logic [AddrW-1:0]          seq_addr;
   logic [LENGTH_W-1:0]       final_len;

   assign n_eff  = (32'(pkt_count_ff) > 32'(MAX_PACKETS)) ? CntW'(MAX_PACKETS)
                                                          : CntW'(pkt_count_ff);
   assign n_prod = ProdW'(n_eff) * ProdW'(RECIP5);

   assign n32      = 32'(n_eff);
   assign h32      = 32'(high_ff);
   assign seq32    = item_seq_ff;
   assign dp32     = 32'(dp_ff);
   assign cur32    = 32'(cur_ff);
   assign lim32    = 32'(lim_ff);
   assign seq_bit  = item_seq_ff[BIT_IDX_W-1:0];
   assign seq_addr = item_seq_ff[BIT_IDX_W +: AddrW];
   assign in_range = !seq32[31] && (seq32 < n32);
   assign hit      = mem_rdata[seq_bit];
   assign fresh    = in_range && !hit;

   // The prefix walk and the NACK scan share one word search.
   assign pos32  = (cmd.addr_sel == ADDR_PREFIX) ? dp32 : cur32;
   assign base32 = pos32 & ~32'(MAP_WORD_BITS - 1);
   assign search = first_set(~mem_rdata & ({MAP_WORD_BITS{1'b1}} << pos32[BIT_IDX_W-1:0]));
   assign found  = search[BIT_IDX_W];
   assign cand32 = found ? base32 + 32'(search[BIT_IDX_W-1:0]) : base32 + 32'(MAP_WORD_BITS);

   assign hor32 = (5 * h32 > 4 * n32) ? h32 + 32'(n_div5_ff) : h32;
   assign limit_new32 = (hor32 + 32'd1 < n32) ? hor32 + 32'd1 : n32;

   assign final_len = (32'(last_bytes_ff) > 32'(PAYLOAD_BYTES)) ? LENGTH_W'(PAYLOAD_BYTES)
                                                                : last_bytes_ff;
   assign complete_now = (count_ff == n_eff);

   always_comb begin
      status.clear_last  = (32'(clr_ff) == 32'(Words - 1));
      status.tick_active = rec_ff && !complete_now;
      status.pfx_go      = dp_ff < lim_ff;
      status.pfx_cont    = !found && (base32 + 32'(MAP_WORD_BITS) < lim32);
      status.scan_go     = cur_ff < n_eff;
      status.scan_cont   = !(found && cand32 < n32) && (base32 + 32'(MAP_WORD_BITS) < n32);
      status.out_free    = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.addr_sel)
         ADDR_CLEAR:  mem_raddr = clr_ff;
         ADDR_ITEM:   mem_raddr = seq_addr;
         ADDR_PREFIX: mem_raddr = dp32[BIT_IDX_W +: AddrW];
         ADDR_CURSOR: mem_raddr = cur32[BIT_IDX_W +: AddrW];
         default:     mem_raddr = seq_addr;
      endcase
   end

   assign mem_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_ARR_CHECK && fresh);
   assign mem_waddr = (cmd.op == OP_CLEAR) ? clr_ff : seq_addr;
   assign mem_wdata = (cmd.op == OP_CLEAR) ? '0
                                           : (mem_rdata | (MAP_WORD_BITS'(1) << seq_bit));

   always_comb begin
      dp_in       = dp_ff;
      high_in     = high_ff;
      count_in    = count_ff;
      sp_in       = sp_ff;
      rec_in      = rec_ff;
      cur_in      = cur_ff;
      lim_in      = lim_ff;
      res_kind_in = res_kind_ff;
      res_off_in  = res_off_ff;
      res_len_in  = res_len_ff;
      res_nack_in = res_nack_ff;
      case (cmd.op)
         OP_LOAD: begin
            res_off_in  = '0;
            res_len_in  = '0;
            res_nack_in = '0;
         end
         OP_ARR_CHECK: begin
            if (fresh) begin
               if (CntW'(seq32) > CntW'(high_ff)) high_in = SeqW'(seq32);
               count_in    = count_ff + CntW'(1);
               res_kind_in = KIND_ACCEPTED;
               res_off_in  = OFFSET_W'(seq32 * 32'(PAYLOAD_BYTES));
               res_len_in  = (seq32 == n32 - 32'd1) ? final_len : LENGTH_W'(PAYLOAD_BYTES);
            end else begin
               res_kind_in = KIND_DROPPED;
            end
         end
         OP_RECOVER: begin
            if (!complete_now && (5 * h32 >= 4 * n32)) rec_in = 1'b1;
         end
         OP_TICK_START: begin
            lim_in = CntW'(limit_new32);
            if (!status.tick_active) res_kind_in = KIND_IDLE;
         end
         OP_PFX_CHECK: begin
            dp_in = (cand32 < lim32) ? CntW'(cand32) : lim_ff;
         end
         OP_SCAN_START: cur_in = sp_ff;
         OP_SCAN_EXHAUST: begin
            sp_in       = dp_ff;
            res_kind_in = KIND_NO_NACK;
         end
         OP_SCAN_CHECK: begin
            if (found && cand32 < n32) begin
               sp_in       = (cand32 == n32 - 32'd1) ? dp_ff : CntW'(cand32 + 32'd1);
               res_kind_in = KIND_NACK;
               res_nack_in = NACK_W'(cand32);
            end else if (status.scan_cont) begin
               cur_in = CntW'(base32 + 32'(MAP_WORD_BITS));
            end else begin
               sp_in       = dp_ff;
               res_kind_in = KIND_NO_NACK;
            end
         end
         default: begin
         end
      endcase
   end

   assign out_load = (cmd.op == OP_FINISH) && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_count_ff  <= PACKET_COUNT_W'(1);
         last_bytes_ff <= LAST_BYTES_W'(1250);
         dp_ff         <= '0;
         high_ff       <= '0;
         count_ff      <= '0;
         sp_ff         <= '0;
         rec_ff        <= 1'b0;
         cur_ff        <= '0;
         lim_ff        <= '0;
         clr_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_PACKET_COUNT: pkt_count_ff <= PACKET_COUNT_W'(csr_write_data);
               CSR_LAST_BYTES:   last_bytes_ff <= csr_write_data[LAST_BYTES_W-1:0];
               default: begin
               end
            endcase
         end
         dp_ff    <= dp_in;
         high_ff  <= high_in;
         count_ff <= count_in;
         sp_ff    <= sp_in;
         rec_ff   <= rec_in;
         cur_ff   <= cur_in;
         lim_ff   <= lim_in;
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + AddrW'(1);
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_div5_ff   <= CntW'(n_prod >> RECIP5_SHIFT);
      res_kind_ff <= res_kind_in;
      res_off_ff  <= res_off_in;
      res_len_ff  <= res_len_in;
      res_nack_ff <= res_nack_in;
      if (cmd.op == OP_LOAD) begin
         item_tick_ff <= req_command;
         item_seq_ff  <= req_seq_num;
      end
      if (out_load) begin
         out_kind_ff     <= res_kind_ff;
         out_off_ff      <= res_off_ff;
         out_len_ff      <= res_len_ff;
         out_nack_ff     <= res_nack_ff;
         out_complete_ff <= complete_now;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_write_offset = out_off_ff;
   assign rsp_write_length = out_len_ff;
   assign rsp_nack_seq     = out_nack_ff;
   assign rsp_complete     = out_complete_ff;

   // Arrival processing only runs on an arrival word.
   a_arrival_only: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_ARR_CHECK |-> !item_tick_ff)
      else $error("arrival check on a tick word");

   // The complete-prefix pointer never moves backwards.
   a_prefix_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> dp_ff >= $past(dp_ff))
      else $error("complete-prefix pointer moved backwards");

   // Recovery, once on, stays on until reset.
   a_recovery_sticky: assert property (@(posedge clock) disable iff (reset)
      rec_ff |=> rec_ff)
      else $error("recovery flag dropped");
endmodule

FILE: design/nack_receive_scoreboard_unit.sv
`timescale 1ns / 1ps
// NACK receive scoreboard: top level joining controller, datapath and seen bitmap.
//
// Each request word is a packet arrival or a NACK timer tick and yields exactly one
// response word. The seen bitmap lives in a RAM of 32-bit words; after reset a clearing
// pass writes every word once before the first request is taken, while register writes
// are accepted throughout. An arrival takes a bitmap read, a read-modify-write, a
// recovery check and the hand-over to the response register, in that order. A tick
// reads the bitmap word by word, first while the complete-prefix pointer advances and
// then while the NACK scan looks for a hole; both walks can cover nearly the whole map
// in one tick. A finished response waits in its own register, so the next request is
// taken while the previous response is still unclaimed.
module nack_receive_scoreboard_unit import nrs_pkg::*; #(
   parameter int unsigned MAX_PACKETS   = MAX_PACKETS_DEFAULT,
   parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   nrs_req_if.sink                req,
   nrs_rsp_if.source              rsp,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);
   localparam int unsigned Words = (MAX_PACKETS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;

   ctrl_cmd_type             cmd;
   dp_status_type            status;
   logic                     mem_we;
   logic [AddrW-1:0]         mem_waddr, mem_raddr;
   logic [MAP_WORD_BITS-1:0] mem_wdata, mem_rdata;

   nrs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.command),
      .req_ready   (req.ready),
      .status      (status),
      .cmd         (cmd)
   );

   nrs_datapath #(
      .MAX_PACKETS   (MAX_PACKETS),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req.command),
      .req_seq_num      (req.seq_num),
      .cmd              (cmd),
      .status           (status),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_result_kind  (rsp.result_kind),
      .rsp_write_offset (rsp.write_offset),
      .rsp_write_length (rsp.write_length),
      .rsp_nack_seq     (rsp.nack_seq),
      .rsp_complete     (rsp.complete)
   );

   nrs_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (Words)
   ) u_seen_map (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );
endmodule
